>>> design/teq_pkg.sv
package teq_pkg;

   localparam int ID_W         = 32;
   localparam int TIME_W       = 48;
   localparam int IVL_W        = 32;
   localparam int REQ_W        = 2;
   localparam int STAT_W       = 2;
   localparam int CAPACITY_DEF = 32;
   localparam int MAX_FIRE     = 32;

   localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_INV  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

endpackage

>>> design/teq_req_if.sv
interface teq_req_if;
   logic                      valid;
   logic                      ready;
   logic [teq_pkg::REQ_W-1:0]  req_type;
   logic [teq_pkg::ID_W-1:0]   timer_id;
   logic [teq_pkg::TIME_W-1:0] expire_time;
   logic [teq_pkg::IVL_W-1:0]  interval;
   logic [teq_pkg::TIME_W-1:0] now_time;

   modport source (output valid, req_type, timer_id, expire_time, interval, now_time,
                   input ready);
   modport sink (input valid, req_type, timer_id, expire_time, interval, now_time,
                 output ready);
endinterface

>>> design/teq_rsp_if.sv
interface teq_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [teq_pkg::STAT_W-1:0] status;
   logic                      fired;
   logic [teq_pkg::ID_W-1:0]   fired_id;
   logic                      earliest_changed;
   logic                      pending_empty;
   logic [teq_pkg::TIME_W-1:0] next_expire;
   logic                      last;

   modport source (output valid, status, fired, fired_id, earliest_changed, pending_empty,
                   next_expire, last, input ready);
   modport sink (input valid, status, fired, fired_id, earliest_changed, pending_empty,
                 next_expire, last, output ready);
endinterface

>>> design/teq_ram.sv
module teq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/timer_expiry_queue_core.sv
// Timer queue of CAPACITY slots held in one RAM word per slot ({id, expiry, interval});
// only the slot valid and due bits live in flip-flops. Every request walks the slot RAM
// one slot per cycle. Add and invalidate make one pass, and add then writes the new slot
// in ADD_WR. A tick that fires nothing makes two passes, one for the due set and one for
// the pending summary. A tick that fires N timers makes the due pass, N passes to pick
// them in expiry order (lower slot on ties), each followed by a FIRE state that rearms or
// frees the timer, and the summary pass. Each beat then goes through EMIT_RD, EMIT_OUT
// and EMIT_HOLD, which holds it until the sink is ready. At most MAX_FIRE timers fire per
// tick; the rest fire on a later tick. The next request is taken once the core is back
// in IDLE, after the last beat of the current one has been delivered.
module timer_expiry_queue_core #(
   parameter int CAPACITY = teq_pkg::CAPACITY_DEF
) (
   input logic     clock,
   input logic     reset,
   teq_req_if.sink   req_ch,
   teq_rsp_if.source rsp_ch
);
   import teq_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int NW = $clog2(MAX_FIRE + 1);
   localparam int BW = (MAX_FIRE > 1) ? $clog2(MAX_FIRE) : 1;
   localparam int RW = ID_W + TIME_W + IVL_W;
   localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
   localparam logic [NW-1:0] FIRE_LIMIT = NW'(MAX_FIRE);

   typedef enum logic [2:0] {
      IDLE, SCAN, ADD_WR, FIRE, EMIT_RD, EMIT_OUT, EMIT_HOLD
   } state_type;

   typedef enum logic [1:0] {
      M_ALL, M_INV, M_DUE, M_MIN_DUE
   } mode_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic [AW-1:0] cnt_ff, cnt_in, pidx_ff, pidx_in, bidx_ff, bidx_in;
   logic iss_ff, iss_in, pv_ff, pv_in, bf_ff, bf_in, hit_ff, hit_in;
   logic [CAPACITY-1:0] valid_ff, valid_in, due_ff, due_in;
   logic [TIME_W-1:0] bexp_ff, bexp_in, exp_ff, exp_in, now_ff, now_in;
   logic [ID_W-1:0] bid_ff, bid_in, id_ff, id_in;
   logic [IVL_W-1:0] bivl_ff, bivl_in, ivl_ff, ivl_in;
   logic [REQ_W-1:0] op_ff, op_in;
   logic [NW-1:0] n_ff, n_in, eidx_ff, eidx_in;
   logic [STAT_W-1:0] stat_ff, stat_in;
   logic ech_ff, ech_in, sempty_ff, sempty_in;
   logic [TIME_W-1:0] snext_ff, snext_in;
   logic rv_ff, rv_in, rfired_ff, rfired_in, rech_ff, rech_in;
   logic rempty_ff, rempty_in, rlast_ff, rlast_in;
   logic [STAT_W-1:0] rstat_ff, rstat_in;
   logic [ID_W-1:0] rid_ff, rid_in;
   logic [TIME_W-1:0] rnext_ff, rnext_in;

   logic slot_we;
   logic [AW-1:0] slot_waddr, slot_raddr;
   logic [RW-1:0] slot_wdata, slot_rdata;
   logic buf_we;
   logic [ID_W-1:0] buf_rdata;

   logic [ID_W-1:0] rd_id;
   logic [TIME_W-1:0] rd_exp;
   logic [IVL_W-1:0] rd_ivl;
   logic has_free;
   logic [AW-1:0] free_idx;
   logic [TIME_W:0] rearm_sum;
   logic [TIME_W-1:0] rearm_exp;
   logic sel, ech_new, done;

   teq_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_slot_ram (
      .clock  (clock),
      .wr_en  (slot_we),
      .wr_addr(slot_waddr),
      .wr_data(slot_wdata),
      .rd_addr(slot_raddr),
      .rd_data(slot_rdata)
   );

   teq_ram #(.WIDTH(ID_W), .DEPTH(MAX_FIRE)) u_fire_buf (
      .clock  (clock),
      .wr_en  (buf_we),
      .wr_addr(n_ff[BW-1:0]),
      .wr_data(bid_ff),
      .rd_addr(eidx_ff[BW-1:0]),
      .rd_data(buf_rdata)
   );

   assign rd_id  = slot_rdata[RW-1 -: ID_W];
   assign rd_exp = slot_rdata[IVL_W +: TIME_W];
   assign rd_ivl = slot_rdata[IVL_W-1:0];
   assign slot_raddr = cnt_ff;

   always_comb begin
      has_free = 1'b0;
      free_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            has_free = 1'b1;
            free_idx = AW'(i);
         end
      end
   end

   assign rearm_sum = {1'b0, now_ff} + {{(TIME_W + 1 - IVL_W){1'b0}}, bivl_ff};
   assign rearm_exp = rearm_sum[TIME_W] ? TIME_MAX : rearm_sum[TIME_W-1:0];
   assign ech_new   = !bf_ff || (exp_ff < bexp_ff);

   always_comb begin
      state_in = state_ff;  mode_in = mode_ff;  cnt_in = cnt_ff;  pidx_in = pidx_ff;
      bidx_in = bidx_ff;    iss_in = iss_ff;    pv_in = 1'b0;     bf_in = bf_ff;
      hit_in = hit_ff;      valid_in = valid_ff; due_in = due_ff; bexp_in = bexp_ff;
      exp_in = exp_ff;      now_in = now_ff;    bid_in = bid_ff;  id_in = id_ff;
      bivl_in = bivl_ff;    ivl_in = ivl_ff;    op_in = op_ff;    n_in = n_ff;
      eidx_in = eidx_ff;    stat_in = stat_ff;  ech_in = ech_ff;  sempty_in = sempty_ff;
      snext_in = snext_ff;  rv_in = rv_ff;      rfired_in = rfired_ff; rech_in = rech_ff;
      rempty_in = rempty_ff; rlast_in = rlast_ff; rstat_in = rstat_ff; rid_in = rid_ff;
      rnext_in = rnext_ff;
      slot_we = 1'b0;  slot_waddr = bidx_ff;  slot_wdata = {bid_ff, rearm_exp, bivl_ff};
      buf_we = 1'b0;   sel = 1'b0;  done = 1'b0;

      unique case (state_ff)
         IDLE: begin
            if (req_ch.valid) begin
               op_in = req_ch.req_type;  id_in = req_ch.timer_id;
               exp_in = req_ch.expire_time;  ivl_in = req_ch.interval;
               now_in = req_ch.now_time;
               n_in = '0;  eidx_in = '0;  hit_in = 1'b0;  ech_in = 1'b0;
               stat_in = STAT_OK;  due_in = '0;  bf_in = 1'b0;
               cnt_in = '0;  iss_in = 1'b1;  state_in = SCAN;
               if (req_ch.req_type == REQ_INV) begin
                  mode_in = M_INV;
               end else if (req_ch.req_type == REQ_TICK) begin
                  mode_in = M_DUE;
               end else begin
                  mode_in = M_ALL;
               end
            end
         end
         SCAN: begin
            if (iss_ff) begin
               pv_in = 1'b1;
               pidx_in = cnt_ff;
               if (cnt_ff == LAST_SLOT) begin
                  iss_in = 1'b0;
               end else begin
                  cnt_in = cnt_ff + AW'(1);
               end
            end
            if (pv_ff) begin
               unique case (mode_ff)
                  M_ALL:     sel = valid_ff[pidx_ff];
                  M_INV: begin
                     sel = valid_ff[pidx_ff] && (rd_id != id_ff);
                     if (valid_ff[pidx_ff] && (rd_id == id_ff)) begin
                        valid_in[pidx_ff] = 1'b0;
                        hit_in = 1'b1;
                     end
                  end
                  M_DUE: begin
                     if (valid_ff[pidx_ff] && (rd_exp < now_ff)) begin
                        due_in[pidx_ff] = 1'b1;
                     end
                  end
                  M_MIN_DUE: sel = due_ff[pidx_ff];
                  default:   sel = 1'b0;
               endcase
               if (sel && (!bf_ff || (rd_exp < bexp_ff))) begin
                  bf_in = 1'b1;  bexp_in = rd_exp;  bidx_in = pidx_ff;
                  bid_in = rd_id;  bivl_in = rd_ivl;
               end
               done = (pidx_ff == LAST_SLOT);
            end
            if (done) begin
               unique case (mode_ff)
                  M_DUE: begin
                     bf_in = 1'b0;  cnt_in = '0;  iss_in = 1'b1;
                     mode_in = (due_in == '0) ? M_ALL : M_MIN_DUE;
                  end
                  M_MIN_DUE: state_in = FIRE;
                  default: begin
                     sempty_in = !bf_in;
                     snext_in = bf_in ? bexp_in : '0;
                     if (mode_ff == M_INV) begin
                        stat_in = hit_in ? STAT_OK : STAT_NOT_FOUND;
                     end
                     state_in = (op_ff == REQ_ADD) ? ADD_WR : EMIT_RD;
                  end
               endcase
            end
         end
         ADD_WR: begin
            if (has_free) begin
               slot_we = 1'b1;  slot_waddr = free_idx;
               slot_wdata = {id_ff, exp_ff, ivl_ff};
               valid_in[free_idx] = 1'b1;
               ech_in = ech_new;  stat_in = STAT_OK;  sempty_in = 1'b0;
               snext_in = ech_new ? exp_ff : bexp_ff;
            end else begin
               stat_in = STAT_FULL;
            end
            state_in = EMIT_RD;
         end
         FIRE: begin
            buf_we = 1'b1;
            if (bivl_ff != '0) begin
               slot_we = 1'b1;
            end else begin
               valid_in[bidx_ff] = 1'b0;
            end
            due_in[bidx_ff] = 1'b0;
            n_in = n_ff + NW'(1);
            bf_in = 1'b0;  cnt_in = '0;  iss_in = 1'b1;  state_in = SCAN;
            mode_in = ((due_in == '0) || (n_in == FIRE_LIMIT)) ? M_ALL : M_MIN_DUE;
         end
         EMIT_RD: state_in = EMIT_OUT;
         EMIT_OUT: begin
            rv_in = 1'b1;  rstat_in = stat_ff;  rfired_in = (n_ff != '0);
            rid_in = (n_ff != '0) ? buf_rdata : '0;
            rech_in = ech_ff;  rempty_in = sempty_ff;  rnext_in = snext_ff;
            rlast_in = (n_ff == '0) || ((eidx_ff + NW'(1)) == n_ff);
            state_in = EMIT_HOLD;
         end
         EMIT_HOLD: begin
            if (rsp_ch.ready) begin
               rv_in = 1'b0;
               if (rlast_ff) begin
                  state_in = IDLE;
               end else begin
                  eidx_in = eidx_ff + NW'(1);
                  state_in = EMIT_RD;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;  valid_ff <= '0;  rv_ff <= 1'b0;
         iss_ff <= 1'b0;    pv_ff <= 1'b0;   n_ff <= '0;
      end else begin
         state_ff <= state_in;  valid_ff <= valid_in;  rv_ff <= rv_in;
         iss_ff <= iss_in;      pv_ff <= pv_in;        n_ff <= n_in;
      end
      mode_ff <= mode_in;  cnt_ff <= cnt_in;  pidx_ff <= pidx_in;  bidx_ff <= bidx_in;
      bf_ff <= bf_in;      hit_ff <= hit_in;  due_ff <= due_in;    bexp_ff <= bexp_in;
      exp_ff <= exp_in;    now_ff <= now_in;  bid_ff <= bid_in;    id_ff <= id_in;
      bivl_ff <= bivl_in;  ivl_ff <= ivl_in;  op_ff <= op_in;      eidx_ff <= eidx_in;
      stat_ff <= stat_in;  ech_ff <= ech_in;  sempty_ff <= sempty_in;
      snext_ff <= snext_in; rfired_ff <= rfired_in; rech_ff <= rech_in;
      rempty_ff <= rempty_in; rlast_ff <= rlast_in; rstat_ff <= rstat_in;
      rid_ff <= rid_in;    rnext_ff <= rnext_in;
   end

   assign req_ch.ready            = (state_ff == IDLE);
   assign rsp_ch.valid            = rv_ff;
   assign rsp_ch.status           = rstat_ff;
   assign rsp_ch.fired            = rfired_ff;
   assign rsp_ch.fired_id         = rid_ff;
   assign rsp_ch.earliest_changed = rech_ff;
   assign rsp_ch.pending_empty    = rempty_ff;
   assign rsp_ch.next_expire      = rnext_ff;
   assign rsp_ch.last             = rlast_ff;

`ifndef ASSERT_OFF
   a_ready_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !rv_ff) else $error("request taken while a beat is pending");
   a_fire_limit: assert property (@(posedge clock) disable iff (reset)
      n_ff <= FIRE_LIMIT) else $error("fire count above limit");
   a_fire_has_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FIRE) |-> (bf_ff && due_ff[bidx_ff]))
      else $error("fire without a due timer picked");
`endif
endmodule
